// ===== design/sha_pkg.sv =====
// Package: SHA-256 constants, round functions and shared item types.
package sha_pkg;

	localparam int LenBitsDefault = 61;
	localparam int QueueDepthDefault = 4;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Front-to-back command: the classified item.
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  count;
		logic        last;
	} cmd_t;

	localparam logic [31:0] InitWords [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ===== design/sha_front.sv =====
// Front end: accept items, clamp the byte count, queue them for the engine.
module sha_front #(
	parameter int QUEUE_DEPTH = sha_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sha_pkg::in_item_t in_item,
	output logic             cmd_valid,
	input  logic             cmd_take,
	output sha_pkg::cmd_t    cmd
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	sha_pkg::cmd_t     slot_q [QUEUE_DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       fill_q;
	logic              push, pop;
	sha_pkg::cmd_t     cls;

	always_comb begin
		cls.data  = in_item.data_word;
		cls.count = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
		cls.last  = in_item.last;
	end

	assign in_stall  = (fill_q == (AW+1)'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			fill_q <= fill_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ===== design/sha_back.sv =====
// Back end: block assembly, padding, one-round-per-cycle compression, optional double-hash pass, output.
module sha_back #(
	parameter int LEN_BITS = sha_pkg::LenBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              double_hash,
	input  logic              cmd_valid,
	output logic              cmd_take,
	input  sha_pkg::cmd_t     cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output sha_pkg::out_item_t out_item
);
	localparam logic [2:0] S_IDLE = 3'd0, S_BYTE = 3'd1, S_COMP = 3'd2, S_PAD = 3'd3,
		S_LEN = 3'd4, S_DBL = 3'd5, S_OUT = 3'd6, S_ADD = 3'd7;

	// what the block under compression is: message data, padding that spilled,
	// the final length block, or the second pass of a double hash
	localparam logic [1:0] K_DATA = 2'd0, K_SPILL = 2'd1, K_FINAL = 2'd2, K_SECOND = 2'd3;

	logic [2:0]          st_q;
	logic [31:0]         w_q [16];
	logic [31:0]         v_q [8];
	logic [31:0]         h_q [8];
	logic [LEN_BITS-1:0] cnt_q;
	logic [5:0]          rnd_q;
	logic [31:0]         data_q;
	logic [2:0]          left_q;
	logic                last_q;
	logic [1:0]          kind_q;
	logic [2:0]          oidx_q;
	logic                ov_q;

	logic [5:0]  pos;
	logic [7:0]  cur_byte;
	logic [31:0] wnow, t1, t2;
	logic [63:0] bits;
	logic [3:0]  wi;
	logic [1:0]  bi;

	assign pos      = cnt_q[5:0];
	assign wi       = pos[5:2];
	assign bi       = pos[1:0];
	assign cur_byte = data_q[31:24];
	assign bits     = 64'(cnt_q) << 3;
	assign wnow     = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] :
		sha_pkg::sig1(w_q[rnd_q[3:0] + 4'd14]) + w_q[rnd_q[3:0] + 4'd9] +
		sha_pkg::sig0(w_q[rnd_q[3:0] + 4'd1]) + w_q[rnd_q[3:0]];
	assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha_pkg::RoundK[rnd_q] + wnow;
	assign t2 = sha_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign cmd_take = (st_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_item.digest_word = h_q[oidx_q];
	assign out_item.word_index  = oidx_q;
	assign out_item.last_word   = (oidx_q == 3'd7);

	// write one byte into the schedule word at byte lane bi
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] b,
		input logic [7:0] d);
		logic [31:0] r;
		r = w;
		case (b)
			2'd0:    r[31:24] = d;
			2'd1:    r[23:16] = d;
			2'd2:    r[15:8]  = d;
			default: r[7:0]   = d;
		endcase
		put_byte = r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; cnt_q <= '0; rnd_q <= '0; ov_q <= 1'b0; oidx_q <= '0;
			kind_q <= K_DATA; left_q <= '0; last_q <= 1'b0; data_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitWords[i];
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						data_q <= cmd.data; left_q <= cmd.count; last_q <= cmd.last;
						st_q <= S_BYTE;
					end
				end
				S_BYTE: begin
					if (left_q != 3'd0) begin
						w_q[wi] <= put_byte(w_q[wi], bi, cur_byte);
						data_q  <= data_q << 8;
						left_q  <= left_q - 3'd1;
						cnt_q   <= cnt_q + 1'b1;
						if (pos == 6'd63) begin
							for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
							rnd_q <= '0; kind_q <= K_DATA; st_q <= S_COMP;
						end
					end else if (last_q) begin
						// pad marker, zero the rest of the current word
						w_q[wi] <= put_byte(w_q[wi], bi, 8'h80) &
							~(32'hffffffff >> (8 * (32'(bi) + 1)));
						rnd_q  <= {2'b00, wi} + 6'd1;
						last_q <= 1'b0;
						st_q   <= S_PAD;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_PAD: begin
					// rnd_q counts words to zero here
					if (rnd_q < 6'd16) begin
						w_q[rnd_q[3:0]] <= '0;
						rnd_q <= rnd_q + 6'd1;
					end else if (wi >= 4'd14) begin
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						rnd_q <= '0; kind_q <= K_SPILL; st_q <= S_COMP;
					end else begin
						st_q <= S_LEN;
					end
				end
				S_LEN: begin
					w_q[14] <= bits[63:32]; w_q[15] <= bits[31:0];
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					rnd_q <= '0; kind_q <= K_FINAL; st_q <= S_COMP;
				end
				S_COMP: begin
					if (rnd_q >= 6'd16) w_q[rnd_q[3:0]] <= wnow;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) st_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					case (kind_q)
						K_DATA: begin
							st_q <= S_BYTE;
						end
						K_SPILL: begin
							// padding spilled: length goes into a fresh zero block
							for (int i = 0; i < 14; i++) w_q[i] <= '0;
							st_q <= S_LEN;
						end
						K_FINAL: begin
							if (double_hash) begin
								st_q <= S_DBL;
							end else begin
								st_q <= S_OUT; ov_q <= 1'b1; oidx_q <= '0;
							end
						end
						default: begin
							st_q <= S_OUT; ov_q <= 1'b1; oidx_q <= '0;
						end
					endcase
				end
				S_DBL: begin
					for (int i = 0; i < 8; i++) begin
						w_q[i] <= h_q[i]; h_q[i] <= sha_pkg::InitWords[i];
						v_q[i] <= sha_pkg::InitWords[i];
					end
					w_q[8] <= 32'h80000000;
					for (int i = 9; i < 15; i++) w_q[i] <= '0;
					w_q[15] <= 32'd256;
					rnd_q <= '0; kind_q <= K_SECOND; st_q <= S_COMP;
				end
				S_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							ov_q <= 1'b0; st_q <= S_IDLE; cnt_q <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitWords[i];
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/sha256_stream_hasher.sv =====
// Top level: streaming SHA-256 hasher with optional double hashing.
// The engine handles one item at a time: the take, a step for each byte, then an end check;
// a full block then adds the 64 compression rounds and the chaining add.
// After a last item, padding, the length block and in double mode a second pass run
// before the first digest word; the eight words then leave one per unstalled cycle.
// Reset (arst_n low, asynchronous): initial chaining words, zero count, empty queue.
module sha256_stream_hasher #(
	parameter int LENGTH_COUNTER_BITS = sha_pkg::LenBitsDefault,
	parameter int QUEUE_DEPTH = sha_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sha_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output sha_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	logic          double_hash_q;
	logic          cmd_valid, cmd_take;
	sha_pkg::cmd_t cmd;

	// the user must see that the register is only written while idle; the block leaves that to the user, so always accept
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_hash_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			double_hash_q <= cfg_data;
		end
	end

	sha_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.cmd_valid, .cmd_take, .cmd
	);

	sha_back #(.LEN_BITS(LENGTH_COUNTER_BITS)) u_back (
		.clk, .arst_n, .double_hash(double_hash_q), .cmd_valid, .cmd_take, .cmd,
		.out_valid, .out_stall, .out_item
	);

	// eighth word carries the end mark
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.last_word == (out_item.word_index == 3'd7)))
		else $error("last_word mismatch");
	// words advance in order when taken
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_item.word_index != 3'd7) |=>
		(out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1))
		else $error("digest word order broken");
	// the engine never takes a command while emitting
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cmd_take)
		else $error("command taken during output");
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the streaming SHA-256 hasher: directed table plus random messages.
`timescale 1ns / 100ps

module testbench;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 300;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	sha_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_stall;
	sha_pkg::out_item_t out_item;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;

	sha256_stream_hasher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Predictor state: chaining words, pending block bytes, wrapped byte count.
	logic [31:0] hash_state [8];
	logic [7:0]  pend_bytes [64];
	logic [60:0] msg_bytes;
	logic        dbl_mode;

	sha_pkg::out_item_t digest_q [$];
	int        errors = 0;
	int        cycles = 0;
	bit        idle_free = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Abort on a runaway run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run 64 rounds of one 512-bit block into the chaining words.
	task automatic compress_block(input logic [7:0] blk [64]);
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, t1, t2, a15, a2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wt = w[r];
			end else begin
				a15 = w[(r + 1) & 15];
				a2 = w[(r + 14) & 15];
				wt = (ror32(a2, 17) ^ ror32(a2, 19) ^ (a2 >> 10)) + w[(r + 9) & 15]
					+ (ror32(a15, 7) ^ ror32(a15, 18) ^ (a15 >> 3)) + w[r & 15];
				w[r & 15] = wt;
			end
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[r] + wt;
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic reset_digest();
		for (int i = 0; i < 8; i++)
			hash_state[i] = sha_pkg::InitWords[i];
		msg_bytes = '0;
	endtask

	// Absorb one item; on last, pad, optionally rehash, and queue eight words.
	task automatic absorb_item(input sha_pkg::in_item_t it);
		logic [7:0]  blk [64];
		logic [63:0] bit_len;
		int n, pos;
		n = (it.byte_count > 4) ? 4 : it.byte_count;
		for (int i = 0; i < n; i++) begin
			pos = msg_bytes[5:0];
			pend_bytes[pos] = it.data_word[31 - 8*i -: 8];
			msg_bytes = msg_bytes + 1;
			if (pos == 63)
				compress_block(pend_bytes);
		end
		if (!it.last)
			return;
		pos = msg_bytes[5:0];
		bit_len = {msg_bytes, 3'b000};
		for (int i = 0; i < 64; i++)
			blk[i] = (i < pos) ? pend_bytes[i] : 8'h00;
		blk[pos] = 8'h80;
		if (pos + 1 > 56) begin
			compress_block(blk);
			for (int i = 0; i < 64; i++)
				blk[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			blk[56 + i] = bit_len[63 - 8*i -: 8];
		compress_block(blk);
		if (dbl_mode) begin
			for (int i = 0; i < 64; i++)
				blk[i] = 8'h00;
			for (int i = 0; i < 8; i++)
				{blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]} = hash_state[i];
			blk[32] = 8'h80;
			blk[62] = 8'h01;
			for (int i = 0; i < 8; i++)
				hash_state[i] = sha_pkg::InitWords[i];
			compress_block(blk);
		end
		for (int i = 0; i < 8; i++)
			digest_q.push_back(sha_pkg::out_item_t'{digest_word: hash_state[i],
				word_index: 3'(i), last_word: (i == 7)});
		reset_digest();
	endtask

	// Receive side: random stall, compare each word with the oldest expectation.
	always @(posedge clk) begin
		sha_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, out_item);
					errors++;
				end else begin
					want = digest_q.pop_front();
					if (out_item !== want) begin
						$display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
							$time, want.digest_word, want.word_index, want.last_word,
							out_item.digest_word, out_item.word_index, out_item.last_word);
						errors++;
					end
				end
			end
			out_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 21);
		end
	end

	// Hold the item until accepted; idle before it at random. Valid stays high
	// on return so the next item can follow at once.
	task automatic send_item(input sha_pkg::in_item_t it);
		while (!idle_free && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		absorb_item(it);
	endtask

	// Drop valid, drain every expected word, then let the engine settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		dbl_mode = mode;
	endtask

	function automatic sha_pkg::in_item_t mk(input logic [31:0] d, input int c, input bit l);
		return '{data_word: d, byte_count: 3'(c), last: l};
	endfunction

	// Random message: mostly short, a few spanning several blocks.
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_item(mk($urandom, $urandom_range(7), i == len - 1));
	endtask

	sha_pkg::in_item_t dir_rows [$];
	logic [31:0] known_first [$];
	int          items_sent;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		dbl_mode = 1'b0;
		for (int i = 0; i < 64; i++)
			pend_bytes[i] = 8'h00;
		reset_digest();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message and "abc" (known digests), saturated counts, ignored low bits.
		dir_rows.push_back(mk(32'hffffffff, 0, 1));
		dir_rows.push_back(mk(32'h616263ff, 3, 1));
		dir_rows.push_back(mk(32'hffffffff, 4, 0));
		dir_rows.push_back(mk(32'h00000000, 7, 0));
		dir_rows.push_back(mk(32'hdeadbeef, 5, 0));
		dir_rows.push_back(mk(32'h12345678, 1, 0));
		dir_rows.push_back(mk(32'h9abcdef0, 2, 0));
		dir_rows.push_back(mk(32'h55aa55aa, 6, 1));
		known_first.push_back(32'he3b0c442);
		known_first.push_back(32'hba7816bf);
		foreach (dir_rows[r]) begin
			send_item(dir_rows[r]);
			if (r < known_first.size() && digest_q.size() >= 8
				&& digest_q[digest_q.size() - 8].digest_word !== known_first[r]) begin
				$display("%0t: predictor expected %h actual %h", $time,
					known_first[r], digest_q[digest_q.size() - 8].digest_word);
				errors++;
			end
		end
		// Padding boundaries: 55, 56 and 64 bytes.
		for (int l = 55; l <= 64; l += 1) begin
			if (l == 55 || l == 56 || l == 64) begin
				for (int i = 0; i < l; i++)
					send_item(mk($urandom, 1, i == l - 1));
			end
		end
		write_mode(1'b1);
		send_item(mk(32'h61626300, 3, 1));
		send_item(mk(32'h0, 0, 1));
		write_mode(1'b0);

		// Random part across mode changes, one stretch with no idling.
		items_sent = 0;
		for (int ph = 0; items_sent < 250; ph++) begin
			if (ph % 4 == 0)
				write_mode(ph[2]);
			idle_free = (ph >= 3 && ph <= 5);
			if (ph == 6)
				wait_drained();
			begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 40) : $urandom_range(12, 1);
				send_message(len);
				items_sent += len;
			end
		end
		idle_free = 0;
		send_item(mk($urandom, 4, 0));
		send_item(mk($urandom, 0, 1));
		wait_drained();

		if (errors == 0 && digest_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
design/sha_pkg.sv
design/sha_front.sv
design/sha_back.sv
design/sha256_stream_hasher.sv
tb/sv/testbench.sv
